/* design/dpr_pkg.sv */
// shared types, constants and controller states for the disparity reprojection block
// no dependencies

package dpr_pkg;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 16;
   localparam int DATA_BITS  = 32;
   localparam int DISP_BITS  = 8;
   localparam int COUNT_BITS = 25;

   // homogeneous x/y width, magnitude width and divider widths
   localparam int XW  = ((COORD_BITS + FRAC_BITS + 1 > DATA_BITS) ?
                         COORD_BITS + FRAC_BITS + 1 : DATA_BITS) + 1;
   localparam int WW  = DATA_BITS + DISP_BITS + 1;
   localparam int WMW = WW - 1;
   localparam int RW  = WMW + 2;
   localparam int QW  = 32;
   localparam int MW  = QW + 1;
   localparam int STEP_BITS = $clog2(QW);

   localparam int NLANES = 3;
   localparam int LANE_X = 0;
   localparam int LANE_Y = 1;
   localparam int LANE_Z = 2;

   localparam logic [30:0] MAX_DEPTH_RESET = 31'd196608;
   localparam logic        EDGE_MASK_RESET = 1'b1;
   localparam int          CSR_INDEX_BITS  = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_OFFSET_X         = 3'd0,
      CSR_OFFSET_Y         = 3'd1,
      CSR_FOCAL            = 3'd2,
      CSR_INV_BASELINE     = 3'd3,
      CSR_CENTER_TERM      = 3'd4,
      CSR_MAX_DEPTH        = 3'd5,
      CSR_EDGE_MASK_ENABLE = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] col;
      logic [COORD_BITS-1:0] row;
      logic [DISP_BITS-1:0]  disparity;
      logic                  edge_mark;
      logic                  frame_start;
   } req_type;

   typedef struct packed {
      logic signed [DATA_BITS-1:0] point_x;
      logic signed [DATA_BITS-1:0] point_y;
      logic signed [DATA_BITS-1:0] point_z;
      logic                        point_valid;
      logic [COUNT_BITS-1:0]       valid_count;
   } rsp_type;

   typedef struct packed {
      logic signed [DATA_BITS-1:0] offset_x;
      logic signed [DATA_BITS-1:0] offset_y;
      logic signed [DATA_BITS-1:0] focal;
      logic signed [DATA_BITS-1:0] inv_baseline;
      logic signed [DATA_BITS-1:0] center_term;
      logic [30:0]                 max_depth;
      logic                        edge_mask_enable;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULW,
      ST_ABS,
      ST_CAP,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic calc;
      logic load_abs;
      logic check_cap;
      logic div_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } status_type;

endpackage

/* design/disparity_to_point_reprojection.sv */
// top level of the disparity to 3-d point reprojection block
// depends on dpr_pkg, dpr_csr, dpr_ctrl and dpr_datapath
//
// usage
//   request channel: req_valid / req_stall with req_data (column, row, disparity,
//   edge mark, frame start). a request is taken when req_valid is high and
//   req_stall low. response channel: rsp_valid / rsp_stall with rsp_data
//   (point x, -y, -z in Q16.16, point valid, per-frame valid count).
//   csr channel: csr_valid / csr_ready with csr_index and csr_data; csr_ready is
//   always high, write only while no request is in flight.
//   sequence: the request is registered when taken, then W and the homogeneous
//   x/y are formed, then the magnitudes, then the overflow checks; then the
//   restoring divider, whose three lanes share one divisor, forms one quotient
//   bit per cycle in each lane. no new request is taken until the point is done.
//   the finished point sits in an output register, so the next request is
//   taken while the response is still stalled; a finished point that finds
//   the output register full waits there until it is taken.
//   reset clears the controller, the valid-point counter and the csr values
//   to their defaults (max depth 3.0, edge masking on).

module disparity_to_point_reprojection
   import dpr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [DATA_BITS-1:0]      csr_data
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   dpr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   dpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dpr_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .cmd      (cmd),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

/* design/dpr_csr.sv */
// configuration registers of the reprojection block
// depends on dpr_pkg

module dpr_csr
   import dpr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [DATA_BITS-1:0]      csr_data,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_OFFSET_X:         cfg_in.offset_x         = $signed(csr_data);
            CSR_OFFSET_Y:         cfg_in.offset_y         = $signed(csr_data);
            CSR_FOCAL:            cfg_in.focal            = $signed(csr_data);
            CSR_INV_BASELINE:     cfg_in.inv_baseline     = $signed(csr_data);
            CSR_CENTER_TERM:      cfg_in.center_term      = $signed(csr_data);
            CSR_MAX_DEPTH:        cfg_in.max_depth        = csr_data[30:0];
            CSR_EDGE_MASK_ENABLE: cfg_in.edge_mask_enable = csr_data[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_x         <= '0;
         cfg_ff.offset_y         <= '0;
         cfg_ff.focal            <= '0;
         cfg_ff.inv_baseline     <= '0;
         cfg_ff.center_term      <= '0;
         cfg_ff.max_depth        <= MAX_DEPTH_RESET;
         cfg_ff.edge_mask_enable <= EDGE_MASK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* design/dpr_ctrl.sv */
// sequencing state machine of the reprojection block
// depends on dpr_pkg

module dpr_ctrl
   import dpr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_MULW;
         ST_MULW: state_in = ST_ABS;
         ST_ABS:  state_in = ST_CAP;
         ST_CAP:  state_in = ST_DIV;
         ST_DIV:  if (status.div_last) state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_stall    = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = reset;
            cmd.accept = req_valid && !reset;
         end
         ST_MULW: cmd.calc      = 1'b1;
         ST_ABS:  cmd.load_abs  = 1'b1;
         ST_CAP:  cmd.check_cap = 1'b1;
         ST_DIV:  cmd.div_step  = 1'b1;
         ST_DONE: cmd.load_out  = out_free;
         default: req_stall     = 1'b1;
      endcase
      rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* design/dpr_datapath.sv */
// homogeneous point, three-lane restoring divider, depth test and output register
// depends on dpr_pkg

module dpr_datapath
   import dpr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  cmd_type    cmd,
   input  req_type    req_data,
   output status_type status,
   output rsp_type    rsp_data
);

   localparam logic [MW-1:0] MAG_CAP  = MW'(1) << QW;
   localparam logic [MW-1:0] MAG_HALF = MW'(1) << (DATA_BITS - 1);

   function automatic logic [DATA_BITS-1:0] sat_q(input logic [MW-1:0] mag,
                                                  input logic neg);
      logic [MW-1:0] nmag;
      nmag = -mag;
      if (neg) begin
         return (mag > MAG_HALF) ? {1'b1, {(DATA_BITS-1){1'b0}}} : nmag[DATA_BITS-1:0];
      end
      return (mag >= MAG_HALF) ? {1'b0, {(DATA_BITS-1){1'b1}}} : mag[DATA_BITS-1:0];
   endfunction

   req_type                 req_ff;
   logic signed [XW-1:0]    x_ff, y_ff;
   logic signed [XW-1:0]    x_in, y_in;
   logic signed [WW-1:0]    w_ff, w_in;
   logic signed [WW-1:0]    w_prod;
   logic [RW-1:0]           d_ff;
   logic [WMW-1:0]          wmag;
   logic                    rej_ff, rej_in;
   logic [RW-1:0]           r_ff   [NLANES];
   logic [RW-1:0]           r_in   [NLANES];
   logic [QW-1:0]           q_ff   [NLANES];
   logic [QW-1:0]           q_in   [NLANES];
   logic                    neg_ff [NLANES];
   logic                    cap_ff [NLANES];
   logic [RW:0]             trial  [NLANES];
   logic [MW-1:0]           mag    [NLANES];
   logic [XW-1:0]           xmag, ymag;
   logic [DATA_BITS-1:0]    fmag;
   logic [STEP_BITS-1:0]    step_ff;
   logic [COUNT_BITS-1:0]   count_ff, count_in, count_base;
   logic                    ok;
   rsp_type                 rsp_ff, rsp_in;

   assign x_in   = $signed(XW'({req_ff.col, {FRAC_BITS{1'b0}}})) + XW'(cfg.offset_x);
   assign y_in   = $signed(XW'({req_ff.row, {FRAC_BITS{1'b0}}})) + XW'(cfg.offset_y);
   assign w_prod = cfg.inv_baseline * $signed({1'b0, req_ff.disparity});
   assign w_in   = w_prod + WW'(cfg.center_term);

   assign wmag   = w_ff[WW-1] ? WMW'(-w_ff) : WMW'(w_ff);
   assign xmag   = x_ff[XW-1] ? XW'(-x_ff) : XW'(x_ff);
   assign ymag   = y_ff[XW-1] ? XW'(-y_ff) : XW'(y_ff);
   assign fmag   = cfg.focal[DATA_BITS-1] ? DATA_BITS'(-cfg.focal) : cfg.focal;
   assign rej_in = (w_ff == '0) || (cfg.edge_mask_enable && !req_ff.edge_mark);

   always_comb begin
      for (int l = 0; l < NLANES; l++) begin
         trial[l] = {r_ff[l], 1'b0};
         if (trial[l] >= {1'b0, d_ff}) begin
            r_in[l] = RW'(trial[l] - {1'b0, d_ff});
            q_in[l] = {q_ff[l][QW-2:0], 1'b1};
         end else begin
            r_in[l] = RW'(trial[l]);
            q_in[l] = {q_ff[l][QW-2:0], 1'b0};
         end
         mag[l] = cap_ff[l] ? MAG_CAP : {1'b0, q_ff[l]};
      end
   end

   assign status.div_last = (step_ff == STEP_BITS'(QW - 1));

   always_comb begin
      ok         = !rej_ff && (mag[LANE_Z] < MW'(cfg.max_depth));
      count_base = req_ff.frame_start ? '0 : count_ff;
      count_in   = (ok && (count_base != '1)) ? count_base + 1'b1 : count_base;
      rsp_in.point_x     = ok ? sat_q(mag[LANE_X], neg_ff[LANE_X]) : '0;
      rsp_in.point_y     = ok ? sat_q(mag[LANE_Y], !neg_ff[LANE_Y]) : '0;
      rsp_in.point_z     = ok ? sat_q(mag[LANE_Z], !neg_ff[LANE_Z]) : '0;
      rsp_in.point_valid = ok;
      rsp_in.valid_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
      end
      if (cmd.calc) begin
         x_ff <= x_in;
         y_ff <= y_in;
         w_ff <= w_in;
      end
      if (cmd.load_abs) begin
         d_ff   <= {wmag, 2'b00};
         rej_ff <= rej_in;
         r_ff[LANE_X]   <= RW'(xmag);
         r_ff[LANE_Y]   <= RW'(ymag);
         r_ff[LANE_Z]   <= RW'(fmag);
         neg_ff[LANE_X] <= x_ff[XW-1] ^ w_ff[WW-1];
         neg_ff[LANE_Y] <= y_ff[XW-1] ^ w_ff[WW-1];
         neg_ff[LANE_Z] <= cfg.focal[DATA_BITS-1] ^ w_ff[WW-1];
      end
      if (cmd.check_cap) begin
         step_ff <= '0;
         for (int l = 0; l < NLANES; l++) begin
            cap_ff[l] <= (r_ff[l] >= d_ff);
            q_ff[l]   <= '0;
         end
      end
      if (cmd.div_step) begin
         step_ff <= step_ff + 1'b1;
         for (int l = 0; l < NLANES; l++) begin
            r_ff[l] <= r_in[l];
            q_ff[l] <= q_in[l];
         end
      end
      if (cmd.load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.load_out) begin
         count_ff <= count_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

/* design/dpr_checker.sv */
// port-level checks of the reprojection block and the bind that attaches them
// depends on dpr_pkg and disparity_to_point_reprojection

module dpr_checker
   import dpr_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // one request in flight at a time
   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous one in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.point_valid) |->
      (rsp_data.point_x == '0 && rsp_data.point_y == '0 && rsp_data.point_z == '0))
      else $error("rejected point not zero");

   a_valid_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.point_valid) |-> (rsp_data.valid_count != '0))
      else $error("valid point not counted");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response present after reset");

endmodule

bind disparity_to_point_reprojection dpr_checker u_dpr_checker (.*);

/* verif/tb.sv */
// testbench for the disparity to 3-d point reprojection block
// holds a point scoreboard with its own fixed-point predictor, request drivers and a response monitor
// depends on dpr_pkg and disparity_to_point_reprojection

module tb;
   import dpr_pkg::*;

   class point_scoreboard;
      rsp_type          expected_points[$];
      longint           offset_x;
      longint           offset_y;
      longint           focal;
      longint           inv_baseline;
      longint           center_term;
      logic [30:0]      max_depth;
      logic             edge_mask_enable;
      logic [COUNT_BITS-1:0] valid_points;
      int               errors;

      function new();
         offset_x         = 0;
         offset_y         = 0;
         focal            = 0;
         inv_baseline     = 0;
         center_term      = 0;
         max_depth        = MAX_DEPTH_RESET;
         edge_mask_enable = EDGE_MASK_RESET;
         valid_points     = '0;
         errors           = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [DATA_BITS-1:0] value);
         case (idx)
            CSR_OFFSET_X:         offset_x = longint'($signed(value));
            CSR_OFFSET_Y:         offset_y = longint'($signed(value));
            CSR_FOCAL:            focal = longint'($signed(value));
            CSR_INV_BASELINE:     inv_baseline = longint'($signed(value));
            CSR_CENTER_TERM:      center_term = longint'($signed(value));
            CSR_MAX_DEPTH:        max_depth = value[30:0];
            CSR_EDGE_MASK_ENABLE: edge_mask_enable = value[0];
            default: ;
         endcase
      endfunction

      // magnitude of n * 2^30 / d, truncated and capped at 2^32
      function logic [63:0] quotient_mag(logic [63:0] n, logic [63:0] d);
         logic [63:0] q;
         q = (n << 30) / d;
         return (q > 64'h1_0000_0000) ? 64'h1_0000_0000 : q;
      endfunction

      function longint quotient(longint num, longint w);
         logic        neg;
         logic [63:0] nm;
         logic [63:0] wm;
         logic [63:0] m;
         neg = (num < 0) != (w < 0);
         nm  = (num < 0) ? -num : num;
         wm  = (w < 0) ? -w : w;
         m   = quotient_mag(nm, wm);
         return neg ? -longint'(m) : longint'(m);
      endfunction

      function logic [DATA_BITS-1:0] saturate(longint v);
         if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
         else if (v < -64'sd2147483648) return 32'h8000_0000;
         else return v[31:0];
      endfunction

      function rsp_type project_pixel(req_type p);
         rsp_type r;
         longint  x;
         longint  y;
         longint  w;
         longint  zq;
         longint  zmag;
         logic    keep;
         if (p.frame_start) valid_points = '0;
         x = longint'(p.col) * 65536 + offset_x;
         y = longint'(p.row) * 65536 + offset_y;
         w = inv_baseline * longint'(p.disparity) + center_term;
         keep = (w != 0) && !(edge_mask_enable && !p.edge_mark);
         zq = 0;
         if (keep) begin
            zq   = quotient(focal, w);
            zmag = (zq < 0) ? -zq : zq;
            if (zmag >= longint'(max_depth)) keep = 1'b0;
         end
         r = '0;
         if (keep) begin
            r.point_x     = saturate(quotient(x, w));
            r.point_y     = saturate(-quotient(y, w));
            r.point_z     = saturate(-zq);
            r.point_valid = 1'b1;
            if (valid_points != '1) valid_points = valid_points + 1'b1;
         end
         r.valid_count = valid_points;
         return r;
      endfunction

      function void note_request(req_type p);
         expected_points.push_back(project_pixel(p));
      endfunction

      function void check_point(rsp_type got);
         rsp_type want;
         logic    bad;
         if (expected_points.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected point x=%h y=%h z=%h v=%b n=%0d", got.point_x,
                        got.point_y, got.point_z, got.point_valid, got.valid_count);
            return;
         end
         want = expected_points.pop_front();
         bad  = 1'b0;
         if (got.point_x !== want.point_x) bad = 1'b1;
         if (got.point_y !== want.point_y) bad = 1'b1;
         if (got.point_z !== want.point_z) bad = 1'b1;
         if (got.point_valid !== want.point_valid) bad = 1'b1;
         if (got.valid_count !== want.valid_count) bad = 1'b1;
         if (bad) begin
            errors++;
            if (errors <= 10) begin
               $display("point mismatch: expected x=%h y=%h z=%h v=%b n=%0d",
                        want.point_x, want.point_y, want.point_z, want.point_valid,
                        want.valid_count);
               $display("                got      x=%h y=%h z=%h v=%b n=%0d",
                        got.point_x, got.point_y, got.point_z, got.point_valid,
                        got.valid_count);
            end
         end
      endfunction

      function int pending();
         return expected_points.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [DATA_BITS-1:0]      csr_data = '0;

   point_scoreboard sb = new();
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;

   disparity_to_point_reprojection dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: random stalls, or a long hold-off when one is requested
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left = hold_left - 1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_point(rsp_data);
   end

   task automatic send_pixel(input req_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      sb.note_request(p);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      sb.write_register(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input logic [31:0] ox, input logic [31:0] oy,
                             input logic [31:0] f, input logic [31:0] ib,
                             input logic [31:0] ct, input logic [31:0] md,
                             input logic [31:0] em);
      write_csr(CSR_OFFSET_X, ox);
      write_csr(CSR_OFFSET_Y, oy);
      write_csr(CSR_FOCAL, f);
      write_csr(CSR_INV_BASELINE, ib);
      write_csr(CSR_CENTER_TERM, ct);
      write_csr(CSR_MAX_DEPTH, md);
      write_csr(CSR_EDGE_MASK_ENABLE, em);
   endtask

   function automatic logic [31:0] random_offset();
      case ($urandom_range(7))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return $urandom;
         default: return 32'd0 - ($urandom_range(4095) << 16) + $urandom_range(65535);
      endcase
   endfunction

   task automatic random_config();
      logic [31:0] f;
      logic [31:0] ib;
      logic [31:0] ct;
      logic [31:0] md;
      case ($urandom_range(7))
         0:       f = 32'h8000_0000;
         1:       f = 32'h7FFF_FFFF;
         2:       f = 32'd0;
         default: begin
            f = ($urandom_range(1, 1500) << 16) + $urandom_range(65535);
            if ($urandom_range(4) == 0) f = 32'd0 - f;
         end
      endcase
      case ($urandom_range(7))
         0:       ib = 32'h8000_0000;
         1:       ib = 32'h7FFF_FFFF;
         2:       ib = $urandom;
         default: begin
            ib = $urandom_range(32'h0010_0000, 32'h4000_0000);
            if ($urandom_range(3) == 0) ib = 32'd0 - ib;
         end
      endcase
      case ($urandom_range(3))
         0:       ct = 32'd0;
         1:       ct = $urandom;
         default: ct = $urandom_range(32'h1000_0000) - 32'h0800_0000;
      endcase
      case ($urandom_range(7))
         0:       md = 32'd0;
         1:       md = {1'($urandom_range(1)), 31'd196608};
         2, 3, 4: md = {1'($urandom_range(1)), 31'h7FFF_FFFF};
         default: md = $urandom;
      endcase
      set_config(random_offset(), random_offset(), f, ib, ct, md, $urandom);
   endtask

   function automatic req_type random_pixel();
      req_type p;
      p.col         = COORD_BITS'($urandom);
      p.row         = COORD_BITS'($urandom);
      p.disparity   = ($urandom_range(15) == 0) ? 8'd0 : 8'($urandom);
      p.edge_mark   = ($urandom_range(3) != 0);
      p.frame_start = ($urandom_range(31) == 0);
      return p;
   endfunction

   initial begin
      #15_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: W is zero for every pixel
      send_pixel('{12'd0, 12'd0, 8'd0, 1'b1, 1'b1});
      send_pixel('{12'd4095, 12'd4095, 8'd255, 1'b0, 1'b0});
      drain();

      // unit baseline, focal 3.0: disparity 1 sits exactly on the depth limit
      set_config(32'd0 - (32'd320 << 16), 32'd0 - (32'd240 << 16), 32'd3 << 16,
                 32'h4000_0000, 32'd0, 32'd196608, 32'd1);
      send_pixel('{12'd100, 12'd50, 8'd1, 1'b1, 1'b0});
      send_pixel('{12'd100, 12'd50, 8'd2, 1'b1, 1'b0});
      send_pixel('{12'd4095, 12'd4095, 8'd255, 1'b1, 1'b0});
      send_pixel('{12'd7, 12'd9, 8'd0, 1'b1, 1'b0});
      send_pixel('{12'd7, 12'd9, 8'd2, 1'b0, 1'b0});
      send_pixel('{12'd0, 12'd0, 8'd3, 1'b1, 1'b1});
      send_pixel('{12'd2048, 12'd1024, 8'd128, 1'b1, 1'b0});
      drain();

      // tiny W, edge masking off: quotients overflow both ways
      set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd1, 32'd0, 32'h7FFF_FFFF, 32'd0);
      send_pixel('{12'd4095, 12'd0, 8'd1, 1'b0, 1'b0});
      send_pixel('{12'd0, 12'd4095, 8'd255, 1'b0, 1'b1});
      drain();
      set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0,
                 32'h7FFF_FFFF, 32'hFFFF_FFFE);
      send_pixel('{12'd0, 12'd0, 8'd1, 1'b1, 1'b0});
      send_pixel('{12'd4095, 12'd4095, 8'd255, 1'b0, 1'b0});
      drain();

      // zero depth limit rejects everything
      set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'd0, 32'd1);
      send_pixel('{12'd1, 12'd1, 8'd1, 1'b1, 1'b0});
      send_pixel('{12'd4095, 12'd4095, 8'd255, 1'b1, 1'b0});
      drain();

      // extreme weights: W of -1 caps the depth, W near full scale passes
      set_config(32'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'd1);
      send_pixel('{12'd10, 12'd20, 8'd1, 1'b1, 1'b0});
      send_pixel('{12'd10, 12'd20, 8'd2, 1'b1, 1'b0});
      send_pixel('{12'd4095, 12'd4095, 8'd255, 1'b1, 1'b0});
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 66; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 66; end
            default: begin send_idle_pct = 38; stall_pct = 38; end
         endcase
         for (int k = 0; k < 3; k++) begin
            random_config();
            if (ph == 0 && k == 0) begin
               // hold the response side off long enough for requests to back up
               hold_left = 500;
               repeat (30) send_pixel(random_pixel());
               drain();
            end
            repeat (115) send_pixel(random_pixel());
            drain();
         end
      end

      repeat (40) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
